// ===== rtl/bipr_pkg.sv =====
package bipr_pkg;

  localparam int PIX_W          = 8;
  localparam int WIDTH_FIELD_W  = 11;
  localparam int HEIGHT_FIELD_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_INDEX_W    = 2;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [PIX_W-1:0] PIX_FULL = 8'hff;
  localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

  // Result queue between the window evaluation and the output port.
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // Command handed from the front end to the evaluation stage.
  typedef struct packed {
    op_t              kind;
    logic             sel;         // line store that holds the emitted row
    logic             north_zero;
    logic             west_zero;
    logic             east_zero;
    logic             last;
    logic             fg;
    logic [PIX_W-1:0] south;
  } cmd_t;

  typedef struct packed {
    logic             removed;
    logic             fg;
    logic             last;
    logic [PIX_W-1:0] pixel;
  } result_t;

endpackage

// ===== rtl/bipr_ram.sv =====
module bipr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  // Read-first: a read and a write to the same address return the old word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// ===== rtl/bipr_front.sv =====
module bipr_front import bipr_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int CW         = $clog2(MAX_WIDTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  op_t                    in_op,
  input  logic [PIX_W-1:0]       in_pixel,
  input  logic                   stage_free,
  output logic                   in_ready,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic                   abort,
  output logic                   issue,
  output cmd_t                   cmd,
  output logic                   ram_rd_en,
  output logic [CW-1:0]          ram_addr_a,
  output logic [CW-1:0]          ram_addr_b,
  output logic [1:0]             ram_wr_en,
  output logic [CW-1:0]          ram_wr_addr,
  output logic [PIX_W-1:0]       ram_wr_data
);

  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMPW  = ((WW > WIDTH_FIELD_W) ? WW : WIDTH_FIELD_W) + 1;
  localparam int CMPH  = ((RW > HEIGHT_FIELD_W) ? RW : HEIGHT_FIELD_W) + 1;
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [CW-1:0] last_col_r, last_col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [RW-1:0] last_row_r, last_row_nxt;
  logic          draining_r, draining_nxt;
  logic          fg_r, fg_nxt;

  logic          accept;
  logic          is_push;
  logic          is_drain;
  logic          at_row_end;
  logic          at_drain_end;
  logic [CMPW-1:0] w_ext;
  logic [CMPW-1:0] w_eff;
  logic [CMPH-1:0] h_ext;
  logic [CMPH-1:0] h_eff;

  assign accept       = in_valid & stage_free;
  assign in_ready     = stage_free;
  assign is_push      = accept & (in_op == OP_PUSH) & ~draining_r;
  assign is_drain     = accept & (in_op == OP_DRAIN) & draining_r;
  assign at_row_end   = (col_r == last_col_r);
  assign at_drain_end = (out_col_r == last_col_r);

  // Zero is taken as one; anything beyond the maximum saturates.
  always_comb begin
    w_ext = CMPW'(cfg_wdata[WIDTH_FIELD_W-1:0]);
    h_ext = CMPH'(cfg_wdata[HEIGHT_FIELD_W-1:0]);
    w_eff = w_ext;
    h_eff = h_ext;
    if (w_ext == '0) begin
      w_eff = CMPW'(1);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end
    if (h_ext == '0) begin
      h_eff = CMPH'(1);
    end else if (h_ext > CMPH'(MAX_HEIGHT)) begin
      h_eff = CMPH'(MAX_HEIGHT);
    end
  end

  always_comb begin
    col_nxt      = col_r;
    out_col_nxt  = out_col_r;
    last_col_nxt = last_col_r;
    row_nxt      = row_r;
    last_row_nxt = last_row_r;
    draining_nxt = draining_r;
    fg_nxt       = fg_r;
    abort        = 1'b0;
    if (cfg_we && (cfg_idx == REG_IMAGE_WIDTH || cfg_idx == REG_IMAGE_HEIGHT)) begin
      abort = 1'b1;
      if (cfg_idx == REG_IMAGE_WIDTH) begin
        last_col_nxt = CW'(w_eff - CMPW'(1));
      end else begin
        last_row_nxt = RW'(h_eff - CMPH'(1));
      end
      col_nxt      = '0;
      out_col_nxt  = '0;
      row_nxt      = '0;
      draining_nxt = 1'b0;
      fg_nxt       = 1'b0;
    end else if (is_push) begin
      fg_nxt = fg_r | (in_pixel != PIX_ZERO);
      if (at_row_end) begin
        col_nxt = '0;
        if (row_r == last_row_r) begin
          row_nxt      = '0;
          draining_nxt = 1'b1;
          out_col_nxt  = '0;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end else if (is_drain) begin
      if (at_drain_end) begin
        out_col_nxt  = '0;
        draining_nxt = 1'b0;
        fg_nxt       = 1'b0;
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      out_col_r  <= '0;
      last_col_r <= CW'(RST_W - 1);
      row_r      <= '0;
      last_row_r <= RW'(RST_H - 1);
      draining_r <= 1'b0;
      fg_r       <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      out_col_r  <= out_col_nxt;
      last_col_r <= last_col_nxt;
      row_r      <= row_nxt;
      last_row_r <= last_row_nxt;
      draining_r <= draining_nxt;
      fg_r       <= fg_nxt;
    end
  end

  // A push in the first row only fills the line store.
  assign issue = (is_push & (row_r != '0)) | is_drain;

  always_comb begin
    cmd.kind       = is_drain ? OP_DRAIN : OP_PUSH;
    cmd.sel        = is_drain ? last_row_r[0] : ~row_r[0];
    cmd.north_zero = (row_r == RW'(1));
    cmd.west_zero  = (col_r == '0);
    cmd.east_zero  = at_row_end;
    cmd.last       = is_drain & at_drain_end;
    cmd.fg         = fg_r;
    cmd.south      = in_pixel;
  end

  // Both stores read at the same column; the store being refilled gives north.
  assign ram_rd_en    = accept;
  assign ram_addr_a   = is_drain ? out_col_r : col_r;
  assign ram_addr_b   = col_r + CW'(1);
  assign ram_wr_en[0] = is_push & ~row_r[0];
  assign ram_wr_en[1] = is_push & row_r[0];
  assign ram_wr_addr  = col_r;
  assign ram_wr_data  = in_pixel;

endmodule

// ===== rtl/bipr_queue.sv =====
module bipr_queue import bipr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t        entry_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           pop;

  assign full      = (count_r == QCW'(QDEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid & out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/bipr_back.sv =====
module bipr_back import bipr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  issue,
  input  cmd_t                  cmd,
  input  logic                  abort,
  input  logic [1:0][PIX_W-1:0] rd_a,
  input  logic [1:0][PIX_W-1:0] rd_b,
  output logic                  stage_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output result_t               out_data
);

  logic             s1_valid_r, s1_valid_nxt;
  cmd_t             s1_cmd_r;
  logic [PIX_W-1:0] prev_center_r;
  logic             removed_r, removed_nxt;

  logic             q_full;
  logic             q_push;
  logic [PIX_W-1:0] center;
  logic [PIX_W-1:0] north;
  logic [PIX_W-1:0] west;
  logic [PIX_W-1:0] east;
  logic             interior;
  result_t          res;

  // The store words stay put until the next accepted word, so a stalled
  // entry in this stage still sees its own neighborhood.
  assign q_push       = s1_valid_r & ~q_full;
  assign stage_free   = ~s1_valid_r | ~q_full;
  assign s1_valid_nxt = stage_free ? issue : s1_valid_r;

  always_comb begin
    center   = rd_a[s1_cmd_r.sel];
    north    = s1_cmd_r.north_zero ? PIX_ZERO : rd_a[~s1_cmd_r.sel];
    west     = s1_cmd_r.west_zero ? PIX_ZERO : prev_center_r;
    east     = s1_cmd_r.east_zero ? PIX_ZERO : rd_b[s1_cmd_r.sel];
    interior = (s1_cmd_r.kind == OP_PUSH) && (center != PIX_ZERO) &&
               ((north & s1_cmd_r.south & west & east) == PIX_FULL);
    res.pixel   = interior ? PIX_ZERO : center;
    res.last    = s1_cmd_r.last;
    res.fg      = s1_cmd_r.last & s1_cmd_r.fg;
    res.removed = s1_cmd_r.last & removed_r;
  end

  always_comb begin
    removed_nxt = removed_r;
    if (abort) begin
      removed_nxt = 1'b0;
    end else if (q_push) begin
      if (s1_cmd_r.last) begin
        removed_nxt = 1'b0;
      end else if (interior) begin
        removed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      removed_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      removed_r  <= removed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_free && issue) begin
      s1_cmd_r <= cmd;
    end
    if (q_push && s1_cmd_r.kind == OP_PUSH) begin
      prev_center_r <= center;
    end
  end

  bipr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/binary_interior_pixel_remover_core.sv =====
// Streams a binary image in raster order and clears every nonzero pixel whose
// four neighbors are all 0xff, using two line stores of MAX_WIDTH pixels each.
// One word is accepted per clock while the evaluation stage is free, so with no
// bubbles unless the result queue backs up: the front end advances the counters
// and issues all line store reads and the write in the accept cycle, the result
// is formed in the next cycle and waits in a two-entry queue. Results lag the
// input by one row; after the last pixel of the frame, send image_width drain
// words to flush the last row, whose final word carries tlast and the two
// summary flags. Drain words at other times and pixel words during the flush
// are consumed with no result. A write to either register restarts the frame;
// writes to other indexes are ignored. The line stores need no clearing after
// reset.
module binary_interior_pixel_remover_core import bipr_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PIX_W-1:0]       in_tdata,   // pixel_in
  input  logic                   in_tuser,   // operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [PIX_W-1:0]       out_tdata,  // pixel_out
  output logic                   out_tlast,
  output logic [1:0]             out_tuser,  // interior_removed, foreground_seen
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                  stage_free;
  logic                  abort;
  logic                  issue;
  cmd_t                  cmd;
  logic                  ram_rd_en;
  logic [CW-1:0]         ram_addr_a;
  logic [CW-1:0]         ram_addr_b;
  logic [1:0]            ram_wr_en;
  logic [CW-1:0]         ram_wr_addr;
  logic [PIX_W-1:0]      ram_wr_data;
  logic [1:0][PIX_W-1:0] rd_a;
  logic [1:0][PIX_W-1:0] rd_b;
  result_t               res;

  assign cfg_ready = 1'b1;

  bipr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_op       (op_t'(in_tuser)),
    .in_pixel    (in_tdata),
    .stage_free  (stage_free),
    .in_ready    (in_tready),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .abort       (abort),
    .issue       (issue),
    .cmd         (cmd),
    .ram_rd_en   (ram_rd_en),
    .ram_addr_a  (ram_addr_a),
    .ram_addr_b  (ram_addr_b),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data)
  );

  for (genvar k = 0; k < 2; k++) begin : g_line
    bipr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk       (clk),
      .wr_en     (ram_wr_en[k]),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr_a (ram_addr_a),
      .rd_addr_b (ram_addr_b),
      .rd_data_a (rd_a[k]),
      .rd_data_b (rd_b[k])
    );
  end

  bipr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .cmd        (cmd),
    .abort      (abort),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .stage_free (stage_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (res)
  );

  assign out_tdata = res.pixel;
  assign out_tlast = res.last;
  assign out_tuser = {res.removed, res.fg};

endmodule

// ===== rtl/bipr_checker.sv =====
module bipr_checker import bipr_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [PIX_W-1:0]       in_tdata,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [PIX_W-1:0]       out_tdata,
  input logic                   out_tlast,
  input logic [1:0]             out_tuser,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // The summary flags only ride on the final word of a frame.
  a_flags_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == 2'b00)
    else $error("summary flags set on a word that is not last");

  // A pixel can only be removed if it was foreground.
  a_removed_needs_fg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("removal reported without foreground");

  // Nothing is pending right after reset.
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind binary_interior_pixel_remover_core bipr_checker u_bipr_checker (.*);

// ===== tb/tb_binary_interior_pixel_remover_core.sv =====
module tb_binary_interior_pixel_remover_core import bipr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 800_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_WORDS  = 600;
  localparam int LONG_HOLD     = 300;

  // Indexes that map to no register.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum {FRAME_WHOLE, FRAME_CUT_PUSHES, FRAME_CUT_DRAIN} frame_shape_t;

  class perimeter_scoreboard;
    localparam int ROW_MAX    = 1024;
    localparam int HEIGHT_MAX = 4096;

    logic [PIX_W-1:0]          line_rows [2][ROW_MAX];
    logic [WIDTH_FIELD_W-1:0]  width_reg;
    logic [HEIGHT_FIELD_W-1:0] height_reg;
    int                        in_col, in_row, out_col, out_row;
    bit                        fg_flag, rm_flag, flushing;
    result_t                   pending_pixels [$];
    int                        mismatches, checked, frames_closed, cleared_pixels;

    function new();
      foreach (line_rows[i, j]) line_rows[i][j] = PIX_ZERO;
      width_reg  = WIDTH_FIELD_W'(RESET_WIDTH);
      height_reg = HEIGHT_FIELD_W'(RESET_HEIGHT);
      start_frame();
    endfunction

    function void start_frame();
      in_col   = 0;
      in_row   = 0;
      out_col  = 0;
      out_row  = 0;
      fg_flag  = 1'b0;
      rm_flag  = 1'b0;
      flushing = 1'b0;
    endfunction

    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > ROW_MAX) return ROW_MAX;
      return width_reg;
    endfunction

    function int eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > HEIGHT_MAX) return HEIGHT_MAX;
      return height_reg;
    endfunction

    function int pending_count();
      return pending_pixels.size();
    endfunction

    function void queue_result(result_t want);
      pending_pixels.insert(pending_pixels.size(), want);
    endfunction

    // A write to either size register restarts the frame but leaves the line stores alone.
    function void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = data[WIDTH_FIELD_W-1:0];
        start_frame();
      end else if (idx == REG_IMAGE_HEIGHT) begin
        height_reg = data[HEIGHT_FIELD_W-1:0];
        start_frame();
      end
    endfunction

    function void note_word(op_t op, logic [PIX_W-1:0] px);
      int               w, h, cur, nxt;
      logic [PIX_W-1:0] center, north, west, east;
      result_t          want;
      w    = eff_width();
      h    = eff_height();
      want = '0;
      if (op == OP_PUSH) begin
        if (flushing) return;
        if (px != PIX_ZERO) fg_flag = 1'b1;
        // The pushed pixel is the south neighbor of the pixel one row up.
        if (in_row >= 1) begin
          cur    = (in_row - 1) & 1;
          nxt    = in_row & 1;
          center = line_rows[cur][in_col];
          north  = (in_row == 1) ? PIX_ZERO : line_rows[nxt][in_col];
          west   = (in_col == 0) ? PIX_ZERO : line_rows[cur][in_col-1];
          east   = (in_col + 1 >= w) ? PIX_ZERO : line_rows[cur][in_col+1];
          want.pixel = center;
          if (center != PIX_ZERO && (north & px & west & east) == PIX_FULL) begin
            want.pixel = PIX_ZERO;
            rm_flag    = 1'b1;
            cleared_pixels++;
          end
          queue_result(want);
        end
        line_rows[in_row & 1][in_col] = px;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
          if (in_row >= h) begin
            flushing = 1'b1;
            out_row  = h - 1;
            out_col  = 0;
          end
        end
      end else begin
        if (!flushing) return;
        want.pixel = line_rows[out_row & 1][out_col];
        if (out_col + 1 >= w) begin
          want.last    = 1'b1;
          want.fg      = fg_flag;
          want.removed = rm_flag;
          start_frame();
        end else begin
          out_col++;
        end
        queue_result(want);
      end
    endfunction

    function void check_word(logic [PIX_W-1:0] pixel, logic last, logic fg_seen,
                             logic removed);
      result_t want;
      checked++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected output word: pixel_out %0h tlast %0b", pixel, last);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      if (pixel !== want.pixel) begin
        $error("pixel_out: expected %0h, got %0h", want.pixel, pixel);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
      if (fg_seen !== want.fg) begin
        $error("foreground_seen: expected %0b, got %0b", want.fg, fg_seen);
        mismatches++;
      end
      if (removed !== want.removed) begin
        $error("interior_removed: expected %0b, got %0b", want.removed, removed);
        mismatches++;
      end
      if (want.last) frames_closed++;
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [PIX_W-1:0]       in_tdata;   // pixel_in
  logic                   in_tuser;   // operation
  logic                   out_tvalid;
  logic                   out_tready;
  logic [PIX_W-1:0]       out_tdata;  // pixel_out
  logic                   out_tlast;
  logic [1:0]             out_tuser;  // interior_removed, foreground_seen
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  perimeter_scoreboard sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;
  int cycle_count;
  int words_accepted;
  int frame_words;
  int cfg_writes;

  binary_interior_pixel_remover_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tdata, out_tlast, out_tuser[0], out_tuser[1]);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d output words outstanding.",
             cycle_count, sb.pending_count());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) return PIX_FULL;
    if (pick < 80) return PIX_ZERO;
    return PIX_W'($urandom_range(255));
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 79;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 79;
      end
      default: begin
        send_idle_pct  = 14;
        recv_stall_pct = 14;
      end
    endcase
  endtask

  // Called at a falling edge; returns at a falling edge with tvalid still high.
  task automatic send_word(input op_t op, input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(op, px);
    words_accepted++;
    @(negedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes follow without a gap.
  task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // A cut frame leaves the block mid-frame; the caller must then rewrite a register.
  task automatic run_frame(input frame_shape_t shape, output bit cut);
    int w, h, n_push, n_drain;
    w       = sb.eff_width();
    h       = sb.eff_height();
    n_push  = w * h;
    n_drain = w;
    cut     = 1'b0;
    if (shape == FRAME_CUT_PUSHES && n_push > 1) begin
      n_push  = $urandom_range(n_push - 1);
      n_drain = 0;
      cut     = 1'b1;
    end else if (shape == FRAME_CUT_DRAIN && w > 1) begin
      n_drain = $urandom_range(w - 1);
      cut     = 1'b1;
    end
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(2, 1)) send_word(OP_DRAIN, rand_pixel());
    for (int i = 0; i < n_push; i++) begin
      send_word(OP_PUSH, rand_pixel());
      frame_words++;
    end
    for (int i = 0; i < n_drain; i++) begin
      if ($urandom_range(19) == 0) send_word(OP_PUSH, rand_pixel());
      send_word(OP_DRAIN, rand_pixel());
      frame_words++;
    end
  endtask

  initial begin
    logic [PIX_W-1:0] pattern [9];
    int               start_words;
    int               phase;
    int               frames;
    int               w, h, which;
    bit               cut;

    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    out_tready     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    hold_request   = 0;
    hold_left      = 0;
    words_accepted = 0;
    frame_words    = 0;
    cfg_writes     = 0;
    set_idling(IDLE_NONE);
    pattern = '{8'h00, 8'hff, 8'h7f, 8'hff, 8'h01, 8'hff, 8'h80, 8'hff, 8'h55};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 3x3 frame whose center has four full neighbors and must be cleared.
    program_reg(REG_IMAGE_WIDTH, 13'd3);
    program_reg(REG_IMAGE_HEIGHT, 13'd3);
    cfg_valid <= 1'b0;
    send_word(OP_DRAIN, 8'h3c);
    for (int i = 0; i < 3; i++) send_word(OP_PUSH, pattern[i]);
    // An unmapped index must not restart the frame.
    wait_for_results();
    program_reg(REG_SPARE_B, 13'h1abc);
    cfg_valid <= 1'b0;
    for (int i = 3; i < 9; i++) send_word(OP_PUSH, pattern[i]);
    send_word(OP_PUSH, 8'haa);
    repeat (3) send_word(OP_DRAIN, 8'h00);
    wait_for_results();

    // Zero width and height act as a single pixel.
    program_reg(REG_IMAGE_WIDTH, 13'd0);
    program_reg(REG_IMAGE_HEIGHT, 13'd0);
    cfg_valid <= 1'b0;
    send_word(OP_PUSH, 8'h00);
    send_word(OP_DRAIN, 8'hff);
    wait_for_results();

    // Hold the output off long enough for the block to stop taking input.
    program_reg(REG_IMAGE_WIDTH, 13'd16);
    program_reg(REG_IMAGE_HEIGHT, 13'd8);
    cfg_valid <= 1'b0;
    hold_request = LONG_HOLD;
    run_frame(FRAME_WHOLE, cut);
    wait_for_results();

    // Oversized sizes saturate; these frames are cut short and restarted.
    set_idling(IDLE_BOTH);
    program_reg(REG_IMAGE_WIDTH, 13'd4);
    program_reg(REG_IMAGE_HEIGHT, 13'h1fff);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 16; i++) send_word(OP_PUSH, rand_pixel());
    send_word(OP_DRAIN, 8'h00);
    wait_for_results();

    set_idling(IDLE_RECEIVER);
    program_reg(REG_IMAGE_WIDTH, 13'h1fff);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 20; i++) send_word(OP_PUSH, rand_pixel());
    wait_for_results();

    program_reg(REG_IMAGE_WIDTH, 13'd6);
    program_reg(REG_IMAGE_HEIGHT, 13'd4);
    cfg_valid <= 1'b0;

    start_words = frame_words;
    phase       = 0;
    while (frame_words - start_words < RANDOM_WORDS) begin
      set_idling(idle_mode_t'(phase % 4));
      w     = ($urandom_range(9) < 7) ? $urandom_range(8, 1) : $urandom_range(32, 9);
      h     = ($urandom_range(9) < 8) ? $urandom_range(6, 1) : $urandom_range(12, 7);
      which = $urandom_range(2);
      if ($urandom_range(3) == 0)
        program_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                    CFG_DATA_W'($urandom_range(8191)));
      if (which != 1) program_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
      if (which != 0) program_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      cfg_valid <= 1'b0;
      frames = $urandom_range(3, 1);
      for (int f = 0; f < frames; f++) begin
        if ($urandom_range(9) < 8) run_frame(FRAME_WHOLE, cut);
        else run_frame(frame_shape_t'($urandom_range(2, 1)), cut);
        if (cut || frame_words - start_words >= RANDOM_WORDS) break;
      end
      wait_for_results();
      phase++;
    end

    if (sb.pending_count() != 0) begin
      $error("%0d expected output words never arrived", sb.pending_count());
      sb.mismatches++;
    end
    $display("Sent %0d words with %0d register writes over %0d random phases, covering",
             words_accepted, cfg_writes, phase);
    $display("size extremes and ignored words; %0d outputs checked, %0d frames, %0d cleared.",
             sb.checked, sb.frames_closed, sb.cleared_pixels);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
